[design/sac_pkg.sv]
// Package with shared widths, constants, types and the saturation helper of the swept box test.
`default_nettype none
package sac_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Slab distances fit in 35 signed bits, box centers in 33 signed bits.
    localparam int DLT_W   = 35;
    localparam int ORG_W   = 33;
    localparam int NUM_W   = DLT_W - 1 + 16;
    localparam int DIV_QB  = 33;
    localparam int DIV_LAT = DIV_QB + 2;

    localparam logic signed [31:0] T_LOW  = 32'sh8000_0000;
    localparam logic signed [31:0] T_HIGH = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_ONE  = 32'sd65536;

    typedef struct packed {
        logic signed [DLT_W-1:0] nlx;
        logic signed [DLT_W-1:0] flx;
        logic signed [DLT_W-1:0] nly;
        logic signed [DLT_W-1:0] fly;
        logic signed [ORG_W-1:0] ox;
        logic signed [ORG_W-1:0] oy;
        logic signed [31:0]      dx;
        logic signed [31:0]      dy;
    } t_item;

    typedef struct packed {
        logic signed [ORG_W-1:0] ox;
        logic signed [ORG_W-1:0] oy;
        logic signed [31:0]      dx;
        logic signed [31:0]      dy;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = T_HIGH;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = T_LOW;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/sac_front.sv]
// Front part: takes a query word, builds slab distances, box centers and the motion vector.
`default_nettype none
module sac_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_take,
    input  wire logic signed [31:0]  i_mover_x,
    input  wire logic signed [31:0]  i_mover_y,
    input  wire logic        [30:0]  i_mover_width,
    input  wire logic        [30:0]  i_mover_height,
    input  wire logic signed [31:0]  i_speed_x,
    input  wire logic signed [31:0]  i_speed_y,
    input  wire logic signed [31:0]  i_box_x,
    input  wire logic signed [31:0]  i_box_y,
    input  wire logic        [30:0]  i_box_width,
    input  wire logic        [30:0]  i_box_height,
    input  wire logic        [30:0]  i_step_time,
    output logic                     o_valid,
    output sac_pkg::t_item           o_item
);
    import sac_pkg::*;

    logic                    r_v1, r_v2;
    logic signed [DLT_W-1:0] r_nlx, r_flx, r_nly, r_fly;
    logic signed [ORG_W-1:0] r_ox, r_oy;
    logic signed [63:0]      r_px, r_py;
    t_item                   r_item;

    logic signed [DLT_W-1:0] hw, hh, mx, my, bx, by, mw, mh, bw, bh;

    always_comb begin
        hw = $signed({5'b0, i_mover_width[30:1]});
        hh = $signed({5'b0, i_mover_height[30:1]});
        mw = $signed({4'b0, i_mover_width});
        mh = $signed({4'b0, i_mover_height});
        bw = $signed({4'b0, i_box_width});
        bh = $signed({4'b0, i_box_height});
        mx = DLT_W'(i_mover_x);
        my = DLT_W'(i_mover_y);
        bx = DLT_W'(i_box_x);
        by = DLT_W'(i_box_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nlx <= bx - hw - mx - hw;
            r_flx <= bx + bw + mw - hw - mx - hw;
            r_nly <= by - hh - my - hh;
            r_fly <= by + bh + mh - hh - my - hh;
            r_ox  <= ORG_W'(mx + hw);
            r_oy  <= ORG_W'(my + hh);
            r_px  <= i_speed_x * $signed({1'b0, i_step_time});
            r_py  <= i_speed_y * $signed({1'b0, i_step_time});

            r_item.nlx <= r_nlx;
            r_item.flx <= r_flx;
            r_item.nly <= r_nly;
            r_item.fly <= r_fly;
            r_item.ox  <= r_ox;
            r_item.oy  <= r_oy;
            r_item.dx  <= sat32(r_px >>> 16);
            r_item.dy  <= sat32(r_py >>> 16);
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule
`default_nettype wire

[design/sac_queue.sv]
// Short register queue that parts the front from the back.
`default_nettype none
module sac_queue #(
    parameter int DEPTH = sac_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sac_pkg::t_item i_item,
    input  wire logic           i_pop,
    output sac_pkg::t_item      o_item,
    output logic                o_full,
    output logic                o_empty
);
    import sac_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule
`default_nettype wire

[design/sac_div.sv]
// Pipelined signed divider: slab time = distance * 2^16 / motion, saturated to 32 bits.
`default_nettype none
module sac_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [sac_pkg::DLT_W-1:0] i_delta,
    input  wire logic signed [31:0]               i_den,
    output logic signed [31:0]                    o_quo
);
    import sac_pkg::*;

    logic [NUM_W-1:0]  r_rem [DIV_QB+1];
    logic [DIV_QB-1:0] r_q   [DIV_QB+1];
    logic [31:0]       r_dv  [DIV_QB+1];
    logic              r_neg [DIV_QB+1];
    logic              r_ovf [DIV_QB+1];
    logic signed [31:0] r_quo;

    logic [DLT_W-1:0] mag_n;
    logic [31:0]      mag_d;
    logic [NUM_W-1:0] num;

    always_comb begin
        mag_n = i_delta[DLT_W-1] ? DLT_W'(-i_delta) : DLT_W'(i_delta);
        mag_d = i_den[31] ? 32'(-i_den) : 32'(i_den);
        num   = {mag_n[DLT_W-2:0], 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num;
            r_q[0]   <= '0;
            r_dv[0]  <= mag_d;
            r_neg[0] <= i_delta[DLT_W-1] ^ i_den[31];
            // A quotient that needs more than the bits produced below saturates.
            r_ovf[0] <= {15'b0, num} >= {mag_d, 33'b0};
        end
    end

    for (genvar k = 0; k < DIV_QB; k++) begin : g_iter
        localparam int SH = DIV_QB - 1 - k;
        logic [63:0] sub;
        logic        take;
        always_comb begin
            sub  = {32'b0, r_dv[k]} << SH;
            take = {14'b0, r_rem[k]} >= sub;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? r_rem[k] - sub[NUM_W-1:0] : r_rem[k];
                r_q[k+1]   <= {r_q[k][DIV_QB-2:0], take};
                r_dv[k+1]  <= r_dv[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    logic [DIV_QB-1:0]  qf;
    logic signed [33:0] qneg;

    always_comb begin
        qf   = r_q[DIV_QB];
        qneg = -$signed({1'b0, qf});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_QB]) begin
                r_quo <= (r_ovf[DIV_QB] || qf > 33'h0_8000_0000) ? T_LOW : qneg[31:0];
            end else begin
                r_quo <= (r_ovf[DIV_QB] || qf > 33'h0_7FFF_FFFF) ? T_HIGH : qf[31:0];
            end
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

[design/sac_back.sv]
// Back part: four slab dividers, slab ordering, hit decision, contact point and result register.
`default_nettype none
module sac_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire sac_pkg::t_item     i_item,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic                    o_hit,
    output logic signed [31:0]      o_hit_time,
    output logic signed [31:0]      o_contact_x,
    output logic signed [31:0]      o_contact_y,
    output logic signed [1:0]       o_normal_x,
    output logic signed [1:0]       o_normal_y
);
    import sac_pkg::*;

    logic en;
    logic r_out_v;

    assign en      = !r_out_v || i_pop;
    assign o_q_pop = en && !i_q_empty;

    logic signed [31:0] qnx, qfx, qny, qfy;

    sac_div u_div_nx (.i_clk(i_clk), .i_en(en), .i_delta(i_item.nlx), .i_den(i_item.dx),
                      .o_quo(qnx));
    sac_div u_div_fx (.i_clk(i_clk), .i_en(en), .i_delta(i_item.flx), .i_den(i_item.dx),
                      .o_quo(qfx));
    sac_div u_div_ny (.i_clk(i_clk), .i_en(en), .i_delta(i_item.nly), .i_den(i_item.dy),
                      .o_quo(qny));
    sac_div u_div_fy (.i_clk(i_clk), .i_en(en), .i_delta(i_item.fly), .i_den(i_item.dy),
                      .o_quo(qfy));

    logic  r_sv   [DIV_LAT];
    t_side r_side [DIV_LAT];

    logic               r1_v, r2_v, r3_v;
    t_side              r1_side, r2_side;
    logic signed [31:0] r1_nx, r1_fx, r1_ny, r1_fy;
    logic               r2_hit, r3_hit;
    logic signed [31:0] r2_tn, r3_tn;
    logic signed [1:0]  r2_rx, r2_ry, r3_rx, r3_ry;
    logic signed [ORG_W-1:0] r3_ox, r3_oy;
    logic signed [63:0] r3_px, r3_py;

    logic signed [31:0] r_time, r_cx, r_cy;
    logic signed [1:0]  r_nx, r_ny;
    logic               r_hit;

    // Valid bits of the back pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_q_empty;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r1_v    <= r_sv[DIV_LAT-1];
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= r3_v;
        end
    end

    logic signed [31:0] nx0, fx0, ny0, fy0;
    t_side              sd;

    always_comb begin
        sd  = r_side[DIV_LAT-1];
        nx0 = (sd.dx == 32'sd0) ? T_LOW  : qnx;
        fx0 = (sd.dx == 32'sd0) ? T_HIGH : qfx;
        ny0 = (sd.dy == 32'sd0) ? T_LOW  : qny;
        fy0 = (sd.dy == 32'sd0) ? T_HIGH : qfy;
    end

    logic signed [31:0] tn, tf;
    logic               miss;

    always_comb begin
        tn   = (r1_nx > r1_ny) ? r1_nx : r1_ny;
        tf   = (r1_fx < r1_fy) ? r1_fx : r1_fy;
        miss = (r1_side.dx == 32'sd0 && r1_side.dy == 32'sd0) ||
               (r1_nx > r1_fy) || (r1_ny > r1_fx) || (tn > Q_ONE) || (tf < 32'sd0);
    end

    logic signed [63:0] sumx, sumy;

    always_comb begin
        sumx = 64'(r3_ox) + (r3_px >>> 16);
        sumy = 64'(r3_oy) + (r3_py >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0].ox <= i_item.ox;
            r_side[0].oy <= i_item.oy;
            r_side[0].dx <= i_item.dx;
            r_side[0].dy <= i_item.dy;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end

            // Order entry and exit per axis.
            r1_nx   <= (nx0 > fx0) ? fx0 : nx0;
            r1_fx   <= (nx0 > fx0) ? nx0 : fx0;
            r1_ny   <= (ny0 > fy0) ? fy0 : ny0;
            r1_fy   <= (ny0 > fy0) ? ny0 : fy0;
            r1_side <= sd;

            r2_hit  <= !miss;
            r2_tn   <= tn;
            r2_side <= r1_side;
            // The axis entered last gives the normal; a tie gives none.
            r2_rx   <= (r1_nx > r1_ny) ? ((r1_side.dx < 32'sd0) ? 2'sd1 : -2'sd1) : 2'sd0;
            r2_ry   <= (r1_nx < r1_ny) ? ((r1_side.dy < 32'sd0) ? 2'sd1 : -2'sd1) : 2'sd0;

            r3_hit <= r2_hit;
            r3_tn  <= r2_tn;
            r3_rx  <= r2_rx;
            r3_ry  <= r2_ry;
            r3_ox  <= r2_side.ox;
            r3_oy  <= r2_side.oy;
            r3_px  <= r2_tn * r2_side.dx;
            r3_py  <= r2_tn * r2_side.dy;

            r_hit  <= r3_hit;
            r_time <= r3_hit ? r3_tn : 32'sd0;
            r_cx   <= r3_hit ? sat32(sumx) : 32'sd0;
            r_cy   <= r3_hit ? sat32(sumy) : 32'sd0;
            r_nx   <= r3_hit ? r3_rx : 2'sd0;
            r_ny   <= r3_hit ? r3_ry : 2'sd0;
        end
    end

    assign o_empty     = !r_out_v;
    assign o_hit       = r_hit;
    assign o_hit_time  = r_time;
    assign o_contact_x = r_cx;
    assign o_contact_y = r_cy;
    assign o_normal_x  = r_nx;
    assign o_normal_y  = r_ny;

endmodule
`default_nettype wire

[design/swept_aabb_collision_top.sv]
// Top level of the swept box collision test: front, queue, back and checks.
// An accepted query word passes to its result word through
// two front stages, the queue, 35 divider stages and four result stages.
// One word per cycle when nothing stalls; the four pipelined dividers set the depth.
// Reset is synchronous and active low; it empties every stage and the queue at once.
`default_nettype none
module swept_aabb_collision_top #(
    parameter int QUEUE_DEPTH = sac_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_mover_x,
    input  wire logic signed [31:0] i_mover_y,
    input  wire logic        [30:0] i_mover_width,
    input  wire logic        [30:0] i_mover_height,
    input  wire logic signed [31:0] i_speed_x,
    input  wire logic signed [31:0] i_speed_y,
    input  wire logic signed [31:0] i_box_x,
    input  wire logic signed [31:0] i_box_y,
    input  wire logic        [30:0] i_box_width,
    input  wire logic        [30:0] i_box_height,
    input  wire logic        [30:0] i_step_time,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_hit,
    output logic signed [31:0]      o_hit_time,
    output logic signed [31:0]      o_contact_x,
    output logic signed [31:0]      o_contact_y,
    output logic signed [1:0]       o_normal_x,
    output logic signed [1:0]       o_normal_y
);
    import sac_pkg::*;

    // The front advances whenever the queue has room; the back advances whenever
    // its result register is free or being taken, so each side stalls on its own.
    logic  q_full, q_empty, q_pop, f_valid, f_en;
    t_item f_item, q_item;

    assign f_en = !q_full;
    assign full = q_full;

    sac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (f_en),
        .i_take         (push && !q_full),
        .i_mover_x      (i_mover_x),
        .i_mover_y      (i_mover_y),
        .i_mover_width  (i_mover_width),
        .i_mover_height (i_mover_height),
        .i_speed_x      (i_speed_x),
        .i_speed_y      (i_speed_y),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_step_time    (i_step_time),
        .o_valid        (f_valid),
        .o_item         (f_item)
    );

    // The front's last stage moves into the queue in the same cycle it advances.
    sac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_en && f_valid),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_item      (q_item),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hit       (o_hit),
        .o_hit_time  (o_hit_time),
        .o_contact_x (o_contact_x),
        .o_contact_y (o_contact_y),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y)
    );

`ifndef NO_ASSERTIONS
    // A miss carries all-zero result fields.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit) |-> (o_hit_time == 32'sd0 && o_contact_x == 32'sd0 &&
                                o_contact_y == 32'sd0 && o_normal_x == 2'sd0 &&
                                o_normal_y == 2'sd0))
        else $error("miss word carries nonzero fields");

    // A hit never lies beyond the end of the step.
    a_hit_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit) |-> (o_hit_time <= Q_ONE))
        else $error("hit time above one");

    // At most one normal component is set.
    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_normal_x == 2'sd0 || o_normal_y == 2'sd0))
        else $error("both normal components set");

    // A waiting result word holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_contact_x) && $stable(o_hit_time)))
        else $error("waiting result changed");
`endif

endmodule
`default_nettype wire
